// ===== rtl/sfc_pkg.sv =====
// sfc_pkg: shared types and constants for the sphere/frustum cull block.
// Field layout of the stream words, register map and stage load enables.
// No dependencies.
package sfc_pkg;

  // stream field layout, lowest bit first
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned PIDX_W    = 3;
  localparam int unsigned PIDX_LSB  = 0;
  localparam int unsigned NX_LSB    = PIDX_LSB + PIDX_W;
  localparam int unsigned NY_LSB    = NX_LSB + FIELD_W;
  localparam int unsigned NZ_LSB    = NY_LSB + FIELD_W;
  localparam int unsigned W_LSB     = NZ_LSB + FIELD_W;
  localparam int unsigned CX_LSB    = W_LSB + FIELD_W;
  localparam int unsigned CY_LSB    = CX_LSB + FIELD_W;
  localparam int unsigned CZ_LSB    = CY_LSB + FIELD_W;
  localparam int unsigned R_LSB     = CZ_LSB + FIELD_W;
  localparam int unsigned S_USED_W  = R_LSB + FIELD_W;
  localparam int unsigned S_DATA_W  = ((S_USED_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W  = 8;
  localparam int unsigned S_USER_W  = 1;

  // Q16.16 fraction
  localparam int unsigned FRAC_BITS = 16;

  // APB register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] CULL_EN_ADDR = APB_ADDR_W'(0);

  typedef enum logic {
    CMD_PLANE_WR = 1'b0,
    CMD_SPHERE   = 1'b1
  } sfc_cmd_e;

  // per-stage load enables of the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } sfc_ld_t;

endpackage

// ===== rtl/sfc_plane_table.sv =====
// sfc_plane_table: register file of frustum planes, one entry per plane.
// Written by plane-write requests; each entry feeds its own test lane.
// Depends on sfc_pkg.
module sfc_plane_table #(
  parameter int unsigned PLANE_COUNT = 6,
  parameter int unsigned COORD_BITS  = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [sfc_pkg::PIDX_W-1:0]            wr_idx_i,
  input  logic signed [COORD_BITS-1:0]          nx_i,
  input  logic signed [COORD_BITS-1:0]          ny_i,
  input  logic signed [COORD_BITS-1:0]          nz_i,
  input  logic signed [COORD_BITS-1:0]          w_i,
  output logic signed [COORD_BITS-1:0]          nx_o [PLANE_COUNT],
  output logic signed [COORD_BITS-1:0]          ny_o [PLANE_COUNT],
  output logic signed [COORD_BITS-1:0]          nz_o [PLANE_COUNT],
  output logic signed [COORD_BITS-1:0]          w_o  [PLANE_COUNT]
);
  import sfc_pkg::*;

  logic signed [COORD_BITS-1:0] nx_q [PLANE_COUNT];
  logic signed [COORD_BITS-1:0] ny_q [PLANE_COUNT];
  logic signed [COORD_BITS-1:0] nz_q [PLANE_COUNT];
  logic signed [COORD_BITS-1:0] w_q  [PLANE_COUNT];

  // an index past the last plane matches no entry and is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        nx_q[p] <= '0;
        ny_q[p] <= '0;
        nz_q[p] <= '0;
        w_q[p]  <= '0;
      end
    end else if (wr_en_i) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (32'(wr_idx_i) == 32'(p)) begin
          nx_q[p] <= nx_i;
          ny_q[p] <= ny_i;
          nz_q[p] <= nz_i;
          w_q[p]  <= w_i;
        end
      end
    end
  end

  assign nx_o = nx_q;
  assign ny_o = ny_q;
  assign nz_o = nz_q;
  assign w_o  = w_q;

endmodule

// ===== rtl/sfc_plane_test.sv =====
// sfc_plane_test: one plane lane, three register stages.
// S1 products, S2 pair sums, S3 final sign -> cull flag. Depends on sfc_pkg.
module sfc_plane_test #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  sfc_pkg::sfc_ld_t             ld_i,
  input  logic signed [COORD_BITS-1:0] nx_i,
  input  logic signed [COORD_BITS-1:0] ny_i,
  input  logic signed [COORD_BITS-1:0] nz_i,
  input  logic signed [COORD_BITS-1:0] w_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic signed [COORD_BITS-1:0] cz_i,
  input  logic signed [COORD_BITS-1:0] r_i,
  output logic                         cull_o
);
  import sfc_pkg::*;

  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned TW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * COORD_BITS + 3;

  logic signed [PW-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic signed [TW-1:0] t_d, t_q;
  logic signed [SW-1:0] sa_d, sb_d, sa_q, sb_q, sum;
  logic                 cull_q;

  assign px_d = PW'(nx_i) * PW'(cx_i);
  assign py_d = PW'(ny_i) * PW'(cy_i);
  assign pz_d = PW'(nz_i) * PW'(cz_i);
  // w and radius share the Q16 scale, so add first and shift once
  assign t_d  = TW'(w_i) + TW'(r_i);

  assign sa_d = SW'(px_q) + SW'(py_q);
  assign sb_d = SW'(pz_q) + (SW'(t_q) <<< FRAC_BITS);
  assign sum  = sa_q + sb_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      t_q  <= t_d;
    end
    if (ld_i.s2) begin
      sa_q <= sa_d;
      sb_q <= sb_d;
    end
    if (ld_i.s3) begin
      cull_q <= sum[SW-1];
    end
  end

  assign cull_o = cull_q;

endmodule

// ===== rtl/sphere_frustum_cull_top.sv =====
// Sphere/frustum cull: sphere requests pass S1, S2, S3, then the output register.
// Throughput one request per cycle when not stalled; plane writes give no result.
// Each stage holds under backpressure; a free stage collapses bubbles.
// Reset (rst_ni low, async) clears all planes, culling_enable and valid bits.
// Depends on sfc_pkg, sfc_plane_table, sfc_plane_test.
module sphere_frustum_cull_top #(
  parameter int unsigned PLANE_COUNT = 6,
  parameter int unsigned COORD_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // plane_index, normal_x, normal_y, normal_z, plane_offset,
  // center_x, center_y, center_z, sphere_radius, zero pad
  input  logic [sfc_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic [sfc_pkg::S_USER_W-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // inside_res, zero pad
  output logic [sfc_pkg::M_DATA_W-1:0]      m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sfc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sfc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import sfc_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  logic cull_en_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic f1_q, f2_q, f3_q;
  logic inside_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic s_acc, plane_wr, sphere_in;
  sfc_ld_t ld;
  sfc_cmd_e cmd;

  logic signed [CB-1:0] in_nx, in_ny, in_nz, in_w, in_cx, in_cy, in_cz, in_r;
  logic signed [CB-1:0] tab_nx [PLANE_COUNT];
  logic signed [CB-1:0] tab_ny [PLANE_COUNT];
  logic signed [CB-1:0] tab_nz [PLANE_COUNT];
  logic signed [CB-1:0] tab_w  [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] cull;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == CULL_EN_ADDR) begin
      cull_en_q <= pwdata[0];
    end
  end
  assign prdata = (paddr == CULL_EN_ADDR) ? APB_DATA_W'(cull_en_q) : '0;

  // ---------------- stall chain ----------------
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign ld   = '{s1: rdy1, s2: rdy2, s3: rdy3};

  assign s_axis_tready = rdy1;
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign cmd       = sfc_cmd_e'(s_axis_tuser[0]);
  assign plane_wr  = s_acc && (cmd == CMD_PLANE_WR);
  assign sphere_in = s_acc && (cmd == CMD_SPHERE);

  // low CB bits of each field, sign taken from bit CB-1
  assign in_nx = CB'(s_axis_tdata[NX_LSB +: FIELD_W]);
  assign in_ny = CB'(s_axis_tdata[NY_LSB +: FIELD_W]);
  assign in_nz = CB'(s_axis_tdata[NZ_LSB +: FIELD_W]);
  assign in_w  = CB'(s_axis_tdata[W_LSB +: FIELD_W]);
  assign in_cx = CB'(s_axis_tdata[CX_LSB +: FIELD_W]);
  assign in_cy = CB'(s_axis_tdata[CY_LSB +: FIELD_W]);
  assign in_cz = CB'(s_axis_tdata[CZ_LSB +: FIELD_W]);
  assign in_r  = CB'(s_axis_tdata[R_LSB +: FIELD_W]);

  sfc_plane_table #(
    .PLANE_COUNT(PLANE_COUNT),
    .COORD_BITS (CB)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (plane_wr),
    .wr_idx_i(s_axis_tdata[PIDX_LSB +: PIDX_W]),
    .nx_i    (in_nx),
    .ny_i    (in_ny),
    .nz_i    (in_nz),
    .w_i     (in_w),
    .nx_o    (tab_nx),
    .ny_o    (tab_ny),
    .nz_o    (tab_nz),
    .w_o     (tab_w)
  );

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    sfc_plane_test #(
      .COORD_BITS(CB)
    ) u_test (
      .clk_i (clk_i),
      .ld_i  (ld),
      .nx_i  (tab_nx[p]),
      .ny_i  (tab_ny[p]),
      .nz_i  (tab_nz[p]),
      .w_i   (tab_w[p]),
      .cx_i  (in_cx),
      .cy_i  (in_cy),
      .cz_i  (in_cz),
      .r_i   (in_r),
      .cull_o(cull[p])
    );
  end

  // ---------------- valid bits and the check flag ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= sphere_in;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // flag set only when the planes decide the outcome
    if (rdy1) f1_q <= cull_en_q && (in_r > CB'(0));
    if (rdy2) f2_q <= f1_q;
    if (rdy3) f3_q <= f2_q;
    if (rdy4) inside_q <= !(f3_q && (|cull));
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = M_DATA_W'(inside_q);

endmodule

// ===== rtl/sfc_checker.sv =====
// sfc_checker: port-level assertions for sphere_frustum_cull_top.
// Bound to the top level below. Depends on sfc_pkg.
module sfc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sfc_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [sfc_pkg::APB_ADDR_W-1:0] paddr,
  input logic [sfc_pkg::APB_DATA_W-1:0] pwdata,
  input logic [sfc_pkg::APB_DATA_W-1:0] prdata,
  input logic                           pready
);
  import sfc_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped under backpressure");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under backpressure");

  // enable register reads back the value just written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && pready && paddr == CULL_EN_ADDR)
      && paddr == CULL_EN_ADDR |-> prdata[0] == $past(pwdata[0]))
    else $error("culling_enable readback mismatch");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind sphere_frustum_cull_top sfc_checker u_sfc_checker (.*);
